### hw/rtl/pfcb_pkg.sv
// Shared types, constants and blend arithmetic for the pixel fade color blend block.
// Used by pixel_fade_color_blend and its port checker; depends on nothing else.
package pfcb_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_RATE  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 8'd3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [31:0] FOREGROUND_RST = 32'hFFFF_FFFF;
	localparam logic [31:0] BACKGROUND_RST = 32'h0000_00FF;
	localparam logic [8:0]  FADE_RATE_RST  = 9'd51;
	localparam logic [5:0]  SCALE_RST      = 6'd20;

	// field widths
	localparam int unsigned INDEX_W     = 11;
	localparam int unsigned INTENSITY_W = 9;
	localparam int unsigned SCALE_W     = 6;
	localparam int unsigned SCREEN_X_W  = 11;
	localparam int unsigned SCREEN_Y_W  = 10;
	localparam int unsigned CHAN_W      = 8;
	localparam logic [INTENSITY_W-1:0] FULL_ON = 9'd256;

	// stream payload layout
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_FIELDS_W = SCREEN_X_W + SCREEN_Y_W + 4 * CHAN_W;
	localparam int unsigned M_TDATA_W  = 56;
	localparam int unsigned M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	// stages from accept up to and including the output register
	localparam int unsigned PIPE_DEPTH = 3;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [INTENSITY_W-1:0] intensity_t;

	// (bg * (256 - t) + fg * t) >> 8, truncated to a channel
	function automatic chan_t blend_chan(input chan_t bg, input chan_t fg, input intensity_t t);
		logic [INTENSITY_W-1:0] inv;
		logic [16:0] p_bg;
		logic [16:0] p_fg;
		logic [17:0] sum;
		inv  = FULL_ON - t;
		p_bg = 17'(bg) * 17'(inv);
		p_fg = 17'(fg) * 17'(t);
		sum  = {1'b0, p_bg} + {1'b0, p_fg};
		return sum[15:8];
	endfunction

endpackage

### hw/rtl/pixel_fade_color_blend.sv
// Top level of the pixel fade color blend block: intensity memory, update and blend pipeline.
// Depends on pfcb_pkg.
//
// One frame pixel is taken per clock while no clearing pass runs and the output is not
// stalled. The intensity memory read lands with the accepting edge; the intensity update
// with write-back is registered into stage 2, and the position and blend multipliers then
// load the screen position and RGBA color into the output register. Back-to-back requests
// to the same pixel are served by forwarding the last written intensity. After reset the
// intensity memory is cleared one entry a cycle, all FRAME_PIXELS entries (2048 by
// default), during which s_tready stays low; configuration writes are taken at any time.
// FRAME_WIDTH and FRAME_PIXELS must be powers of two with FRAME_PIXELS above FRAME_WIDTH.
module pixel_fade_color_blend
	import pfcb_pkg::*;
#(
	parameter int unsigned FRAME_WIDTH  = 64,
	parameter int unsigned FRAME_PIXELS = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel requests
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [10:0] pixel_index, [11] lit, rest zero
	// colored pixels
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [10:0] screen_x, [20:11] screen_y,
	                                         // [28:21] red, [36:29] green,
	                                         // [44:37] blue, [52:45] alpha, rest zero
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned IDX_W = $clog2(FRAME_PIXELS);
	localparam int unsigned COL_W = $clog2(FRAME_WIDTH);
	localparam int unsigned ROW_W = IDX_W - COL_W;

	// configuration
	logic [31:0]            fg_q;
	logic [31:0]            bg_q;
	logic [INTENSITY_W-1:0] fade_q;
	logic [SCALE_W-1:0]     scale_q;

	// clearing pass
	logic             clearing_q;
	logic [IDX_W-1:0] clr_addr_q;

	// intensity memory
	logic [INTENSITY_W-1:0] mem [FRAME_PIXELS];
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_wa;
	logic [INTENSITY_W-1:0] mem_wd;

	// input decode
	logic [IDX_W+INDEX_W-1:0] idx_ext;
	logic [IDX_W-1:0]         idx_in;
	logic                     in_fire;

	// stage 1: read data arrives, intensity update
	logic                   valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   lit_s1;
	logic [INTENSITY_W-1:0] rd_s1;
	logic [INTENSITY_W-1:0] old_t;
	logic [INTENSITY_W-1:0] new_t;

	// last write, for a read that raced it
	logic                   fwd_valid_q;
	logic [IDX_W-1:0]       fwd_addr_q;
	logic [INTENSITY_W-1:0] fwd_t_q;

	// stage 2: intensity and position
	logic                   valid_s2;
	logic [INTENSITY_W-1:0] t_s2;
	logic [COL_W-1:0]       col_s2;
	logic [ROW_W-1:0]       row_s2;
	logic [COL_W+SCALE_W-1:0] x_prod;
	logic [ROW_W+SCALE_W-1:0] y_prod;

	// output register
	logic                  out_valid_q;
	logic [M_TDATA_W-1:0]  out_data_q;

	logic rdy_out;
	logic rdy_s2;
	logic rdy_s1;
	logic adv_s1;

	assign rdy_out = !out_valid_q || m_tready;
	assign rdy_s2  = !valid_s2 || rdy_out;
	assign rdy_s1  = !valid_s1 || rdy_s2;
	assign adv_s1  = valid_s1 && rdy_s2;

	assign s_tready  = rdy_s1 && !clearing_q;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign idx_ext = {{IDX_W{1'b0}}, s_tdata[INDEX_W-1:0]};
	assign idx_in  = idx_ext[IDX_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q    <= FOREGROUND_RST;
			bg_q    <= BACKGROUND_RST;
			fade_q  <= FADE_RATE_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FOREGROUND: fg_q    <= cfg_data;
				CFG_BACKGROUND: bg_q    <= cfg_data;
				CFG_FADE_RATE:  fade_q  <= cfg_data[INTENSITY_W-1:0];
				CFG_SCALE:      scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// intensity update with forwarding of the last write
	always_comb begin
		old_t = (fwd_valid_q && fwd_addr_q == idx_s1) ? fwd_t_q : rd_s1;
		priority if (lit_s1) begin
			new_t = FULL_ON;
		end else if (old_t > fade_q) begin
			new_t = old_t - fade_q;
		end else begin
			new_t = '0;
		end
	end

	// single write port: clearing pass, then write-back
	always_comb begin
		if (clearing_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else begin
			mem_we = adv_s1;
			mem_wa = idx_s1;
			mem_wd = new_t;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (in_fire) begin
			rd_s1 <= mem[idx_in];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			fwd_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
				if (clr_addr_q == {IDX_W{1'b1}}) begin
					clearing_q <= 1'b0;
				end
			end
			if (adv_s1) begin
				fwd_valid_q <= 1'b1;
			end
			if (rdy_s1) begin
				valid_s1 <= in_fire;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_s1 <= idx_in;
			lit_s1 <= s_tdata[INDEX_W];
		end
		if (adv_s1) begin
			fwd_addr_q <= idx_s1;
			fwd_t_q    <= new_t;
			t_s2       <= new_t;
			col_s2     <= idx_s1[COL_W-1:0];
			row_s2     <= idx_s1[IDX_W-1:COL_W];
		end
		if (valid_s2 && rdy_out) begin
			out_data_q <= {
				{M_PAD_W{1'b0}},
				blend_chan(bg_q[7:0],   fg_q[7:0],   t_s2),
				blend_chan(bg_q[15:8],  fg_q[15:8],  t_s2),
				blend_chan(bg_q[23:16], fg_q[23:16], t_s2),
				blend_chan(bg_q[31:24], fg_q[31:24], t_s2),
				SCREEN_Y_W'(y_prod),
				SCREEN_X_W'(x_prod)
			};
		end
	end

	// products wrap to the field widths
	assign x_prod = (COL_W+SCALE_W)'(col_s2) * (COL_W+SCALE_W)'(scale_q);
	assign y_prod = (ROW_W+SCALE_W)'(row_s2) * (ROW_W+SCALE_W)'(scale_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### hw/rtl/pfcb_checker.sv
// Port-level checker for pixel_fade_color_blend, with the bind that attaches it.
// Depends on pfcb_pkg.
module pfcb_checker
	import pfcb_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic       in_fire;
	logic       out_fire;
	logic [2:0] pending_q;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_fire) - 3'(out_fire);
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> pending_q != 3'd0)
		else $error("result delivered without an accepted request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'(PIPE_DEPTH))
		else $error("more requests in flight than pipeline stages");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0)
		else $error("output padding bits not zero");

endmodule

bind pixel_fade_color_blend pfcb_checker u_pfcb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
